// ===== rtl/bhts_pkg.sv =====
// bhts_pkg: shared codes, field widths and pipeline structs for the
// binary hamming top-k search unit. No dependencies.

package bhts_pkg;

	// item field widths
	localparam int OP_W       = 2;
	localparam int VEC_IDX_W  = 10;
	localparam int WORD_IDX_W = 4;
	localparam int DATA_W     = 64;
	localparam int RANK_W     = 4;
	localparam int INDEX_W    = 10;
	localparam int SIM_W      = 11;
	localparam int PCNT_W     = 7;

	// configuration port
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_K = 2'd2;

	localparam logic [10:0] VECTOR_COUNT_RESET  = 11'd1024;
	localparam logic [3:0]  BLOCKS_IN_USE_RESET = 4'd8;
	localparam logic [4:0]  TOP_K_RESET         = 5'd1;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_LOAD_DB    = 2'd0,
		OP_LOAD_QUERY = 2'd1,
		OP_SEARCH     = 2'd2
	} bhts_op_t;

	// word token travelling with the memory read data
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic zero;
	} bhts_tok_t;

	// control into the ranking list
	typedef struct packed {
		logic clear;
		logic offer;
	} bhts_topk_ctl_t;

	// number of set bits in one 64-bit word
	function automatic logic [PCNT_W-1:0] popcount64(input logic [DATA_W-1:0] x);
		logic [PCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < DATA_W; i++) begin
			n = n + PCNT_W'(x[i]);
		end
		return n;
	endfunction

endpackage

// ===== rtl/bhts_ram.sv =====
// bhts_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.

module bhts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bhts_score.sv =====
// bhts_score: xnor popcount stage and per-vector accumulator.
// Depends on bhts_pkg; fed by the database and query RAM read data.

module bhts_score import bhts_pkg::*; #(
	parameter int WORDS_PER_VECTOR = 16,
	parameter int IDX_W = 10,
	localparam int SCORE_W = $clog2(DATA_W * WORDS_PER_VECTOR + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bhts_tok_t         tok,
	input  logic [IDX_W-1:0]  vidx,
	input  logic [DATA_W-1:0] db_word,
	input  logic [DATA_W-1:0] q_word,
	output logic              offer_valid,
	output logic [SCORE_W-1:0] offer_score,
	output logic [IDX_W-1:0]  offer_index
);

	bhts_tok_t          tok_s2;
	logic [PCNT_W-1:0]  pc_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [SCORE_W-1:0] acc_q;
	logic [SCORE_W-1:0] sum;
	logic               offer_valid_s3;
	logic [SCORE_W-1:0] offer_score_s3;
	logic [IDX_W-1:0]   offer_index_s3;

	// running total, restarted on the first word of a vector
	assign sum = (tok_s2.first ? '0 : acc_q) + SCORE_W'(pc_s2);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2         <= '0;
			offer_valid_s3 <= 1'b0;
		end else begin
			tok_s2         <= tok;
			offer_valid_s3 <= tok_s2.valid && tok_s2.last;
		end
	end

	// popcount of equal bits, then accumulate
	always_ff @(posedge clk) begin
		pc_s2  <= tok.zero ? '0 : popcount64(~(db_word ^ q_word));
		idx_s2 <= vidx;
		if (tok_s2.valid) begin
			acc_q <= sum;
		end
		offer_score_s3 <= sum;
		offer_index_s3 <= idx_s2;
	end

	assign offer_valid = offer_valid_s3;
	assign offer_score = offer_score_s3;
	assign offer_index = offer_index_s3;

endmodule

// ===== rtl/bhts_topk.sv =====
// bhts_topk: sorted list of the best scores, one insertion per cycle.
// Depends on bhts_pkg; scores come from bhts_score.

module bhts_topk import bhts_pkg::*; #(
	parameter int TOP_K_MAX = 16,
	parameter int SCORE_W = 11,
	parameter int IDX_W = 10,
	localparam int KW = $clog2(TOP_K_MAX + 1),
	localparam int RW = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bhts_topk_ctl_t     ctl,
	input  logic [KW-1:0]      k,
	input  logic [SCORE_W-1:0] offer_score,
	input  logic [IDX_W-1:0]   offer_index,
	input  logic [RW-1:0]      rd_sel,
	output logic [SCORE_W-1:0] rd_score,
	output logic [IDX_W-1:0]   rd_index,
	output logic [KW-1:0]      count
);

	logic [SCORE_W-1:0]   sc_q [TOP_K_MAX];
	logic [IDX_W-1:0]     ix_q [TOP_K_MAX];
	logic [SCORE_W-1:0]   sh_sc [TOP_K_MAX];
	logic [IDX_W-1:0]     sh_ix [TOP_K_MAX];
	logic [KW-1:0]        cnt_q;
	logic [TOP_K_MAX-1:0] ge;
	logic [TOP_K_MAX-1:0] prev_ge;
	logic [TOP_K_MAX-1:0] in_k;
	logic                 all_ge;

	// per-cell compare; ties keep the earlier vector ahead
	always_comb begin
		for (int i = 0; i < TOP_K_MAX; i++) begin
			in_k[i] = KW'(i) < k;
			ge[i]   = (KW'(i) < cnt_q) && (sc_q[i] >= offer_score);
		end
		prev_ge = (ge << 1) | TOP_K_MAX'(1);
		all_ge  = &(ge | ~in_k);
		sh_sc[0] = offer_score;
		sh_ix[0] = offer_index;
		for (int i = 1; i < TOP_K_MAX; i++) begin
			sh_sc[i] = sc_q[i-1];
			sh_ix[i] = ix_q[i-1];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.offer && !all_ge && (cnt_q < k)) begin
			cnt_q <= cnt_q + KW'(1);
		end
	end

	// insert at the first weaker cell, shift the rest down
	always_ff @(posedge clk) begin
		for (int i = 0; i < TOP_K_MAX; i++) begin
			if (ctl.offer && in_k[i] && !ge[i]) begin
				sc_q[i] <= prev_ge[i] ? offer_score : sh_sc[i];
				ix_q[i] <= prev_ge[i] ? offer_index : sh_ix[i];
			end
		end
	end

	assign rd_score = sc_q[rd_sel];
	assign rd_index = ix_q[rd_sel];
	assign count    = cnt_q;

endmodule

// ===== rtl/binary_hamming_topk_search_unit.sv =====
// binary_hamming_topk_search_unit: top level with command decode, scan sequencer,
// result emission. Depends on bhts_pkg, bhts_ram, bhts_score and bhts_topk.

// Load commands (database word, query word) are taken one per cycle while busy
// is low and never raise busy. A search raises busy from the cycle after it is
// taken; the scan reads one 64-bit database word per cycle through the single
// read port of the database RAM, covering vector_count vectors of
// max(2 * blocks_in_use, 1) words each, with both limits saturated to what the
// storage holds; the pipeline then drains, the results follow one by one, and
// busy drops as the last result is shown. A search with vector_count or top_k
// zero emits nothing and never raises busy. Results are shown for one cycle
// each with result_valid high and cannot be held off. Database and query memories
// are not cleared at reset: every word a search touches must be loaded first.

module binary_hamming_topk_search_unit import bhts_pkg::*; #(
	parameter int MAX_VECTORS = 1024,
	parameter int WORDS_PER_VECTOR = 16,
	parameter int TOP_K_MAX = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       operation,
	input  logic [VEC_IDX_W-1:0]  vector_index,
	input  logic [WORD_IDX_W-1:0] word_index,
	input  logic [DATA_W-1:0]     data_word,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output logic [RANK_W-1:0]     rank,
	output logic [INDEX_W-1:0]    match_index,
	output logic [SIM_W-1:0]      similarity,
	output logic                  last
);

	localparam int VIW      = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
	localparam int WW       = $clog2(WORDS_PER_VECTOR);
	localparam int DB_DEPTH = MAX_VECTORS * WORDS_PER_VECTOR;
	localparam int DB_AW    = $clog2(DB_DEPTH);
	localparam int SCORE_W  = $clog2(DATA_W * WORDS_PER_VECTOR + 1);
	localparam int KW       = $clog2(TOP_K_MAX + 1);
	localparam int RW       = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1;
	localparam int HALF_WPV = WORDS_PER_VECTOR / 2;
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [10:0]        vc_q;
	logic [3:0]         blk_q;
	logic [4:0]         topk_q;
	logic [VIW-1:0]     v_q;
	logic [WW-1:0]      w_q;
	logic [VIW-1:0]     nm1_q;
	logic [WW-1:0]      wl_q;
	logic               zero_q;
	logic [KW-1:0]      k_q;
	logic [1:0]         drain_q;
	logic [RW-1:0]      r_q;
	bhts_tok_t          tok_s1;
	logic [VIW-1:0]     vidx_s1;
	logic               result_valid_q;
	logic [RANK_W-1:0]  rank_q;
	logic [INDEX_W-1:0] match_q;
	logic [SIM_W-1:0]   sim_q;
	logic               last_q;

	logic               accept;
	logic               do_search;
	logic [31:0]        vc_w;
	logic [31:0]        blk_w;
	logic [VIW-1:0]     nm1_sat;
	logic [WW-1:0]      wl_sat;
	logic [KW-1:0]      k_sat;
	logic               db_we;
	logic               q_we;
	logic [DB_AW-1:0]   db_waddr;
	logic [DB_AW-1:0]   db_raddr;
	logic [DATA_W-1:0]  db_rdata;
	logic [DATA_W-1:0]  q_rdata;
	logic               offer_valid;
	logic [SCORE_W-1:0] offer_score;
	logic [VIW-1:0]     offer_index;
	bhts_topk_ctl_t     topk_ctl;
	logic [SCORE_W-1:0] rd_score;
	logic [VIW-1:0]     rd_index;
	logic [KW-1:0]      count;
	logic               emit_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q   <= VECTOR_COUNT_RESET;
			blk_q  <= BLOCKS_IN_USE_RESET;
			topk_q <= TOP_K_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_VECTOR_COUNT:  vc_q   <= cfg_data;
				CFG_BLOCKS_IN_USE: blk_q  <= cfg_data[3:0];
				CFG_TOP_K:         topk_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// command decode
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign do_search = accept && (operation == OP_SEARCH);

	// search limits, saturated to what the storage holds
	always_comb begin
		vc_w    = 32'(vc_q);
		blk_w   = (32'(blk_q) > HALF_WPV) ? 32'(HALF_WPV) : 32'(blk_q);
		nm1_sat = (vc_w > MAX_VECTORS) ? VIW'(MAX_VECTORS - 1) : VIW'(vc_w - 32'd1);
		wl_sat  = (blk_w == 32'd0) ? '0 : WW'(2 * blk_w - 32'd1);
		k_sat   = (32'(topk_q) > TOP_K_MAX) ? KW'(TOP_K_MAX) : KW'(topk_q);
	end

	// memory write and read ports
	assign db_we = accept && (operation == OP_LOAD_DB)
		&& (32'(vector_index) < MAX_VECTORS) && (32'(word_index) < WORDS_PER_VECTOR);
	assign q_we = accept && (operation == OP_LOAD_QUERY)
		&& (32'(word_index) < WORDS_PER_VECTOR);
	assign db_waddr = DB_AW'(DB_AW'(vector_index) * DB_AW'(WORDS_PER_VECTOR))
		+ DB_AW'(word_index);
	assign db_raddr = DB_AW'(DB_AW'(v_q) * DB_AW'(WORDS_PER_VECTOR)) + DB_AW'(w_q);

	bhts_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DB_DEPTH)
	) u_db_ram (
		.clk  (clk),
		.we   (db_we),
		.waddr(db_waddr),
		.wdata(data_word),
		.raddr(db_raddr),
		.rdata(db_rdata)
	);

	bhts_ram #(
		.WIDTH(DATA_W),
		.DEPTH(WORDS_PER_VECTOR)
	) u_query_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(WW'(word_index)),
		.wdata(data_word),
		.raddr(w_q),
		.rdata(q_rdata)
	);

	bhts_score #(
		.WORDS_PER_VECTOR(WORDS_PER_VECTOR),
		.IDX_W(VIW)
	) u_score (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok        (tok_s1),
		.vidx       (vidx_s1),
		.db_word    (db_rdata),
		.q_word     (q_rdata),
		.offer_valid(offer_valid),
		.offer_score(offer_score),
		.offer_index(offer_index)
	);

	assign topk_ctl.clear = do_search;
	assign topk_ctl.offer = offer_valid;

	bhts_topk #(
		.TOP_K_MAX(TOP_K_MAX),
		.SCORE_W(SCORE_W),
		.IDX_W(VIW)
	) u_topk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (topk_ctl),
		.k          (k_q),
		.offer_score(offer_score),
		.offer_index(offer_index),
		.rd_sel     (r_q),
		.rd_score   (rd_score),
		.rd_index   (rd_index),
		.count      (count)
	);

	assign emit_last = (KW'(r_q) + KW'(1)) == count;

	// sequencer: scan words of every vector, drain, then emit the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			v_q            <= '0;
			w_q            <= '0;
			nm1_q          <= '0;
			wl_q           <= '0;
			zero_q         <= 1'b0;
			k_q            <= '0;
			drain_q        <= '0;
			r_q            <= '0;
			tok_s1         <= '0;
			vidx_s1        <= '0;
			result_valid_q <= 1'b0;
			rank_q         <= '0;
			match_q        <= '0;
			sim_q          <= '0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			tok_s1         <= '0;
			case (state_q)
				S_IDLE: begin
					if (do_search) begin
						nm1_q  <= nm1_sat;
						wl_q   <= wl_sat;
						zero_q <= (blk_w == 32'd0);
						k_q    <= k_sat;
						v_q    <= '0;
						w_q    <= '0;
						if ((vc_q != '0) && (topk_q != '0)) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					tok_s1.valid <= 1'b1;
					tok_s1.first <= (w_q == '0);
					tok_s1.last  <= (w_q == wl_q);
					tok_s1.zero  <= zero_q;
					vidx_s1      <= v_q;
					if (w_q == wl_q) begin
						w_q <= '0;
						if (v_q == nm1_q) begin
							state_q <= S_DRAIN;
							drain_q <= '0;
						end else begin
							v_q <= v_q + VIW'(1);
						end
					end else begin
						w_q <= w_q + WW'(1);
					end
				end
				S_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= S_EMIT;
						r_q     <= '0;
					end else begin
						drain_q <= drain_q + 2'd1;
					end
				end
				S_EMIT: begin
					result_valid_q <= 1'b1;
					rank_q         <= RANK_W'(r_q);
					match_q        <= INDEX_W'(rd_index);
					sim_q          <= SIM_W'(rd_score);
					last_q         <= emit_last;
					r_q            <= r_q + RW'(1);
					if (emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign rank         = rank_q;
	assign match_index  = match_q;
	assign similarity   = sim_q;
	assign last         = last_q;

	// results only come out of the emit phase
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q == S_EMIT))
		else $error("result shown outside emit phase");

	// the final result of a search is never followed directly by another
	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && last_q) |=> !result_valid_q)
		else $error("result follows the last result");

	// the list never holds more entries than the search asked for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= k_q)
		else $error("ranking list overfilled");

	// word tokens are only issued while scanning
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_s1.valid |-> $past(state_q == S_SCAN))
		else $error("word token outside scan");

endmodule
